FILE: src/loa_pkg.sv
// shared constants and helpers for the lower-part or sign-magnitude adder
package loa_pkg;

  localparam int MAX_WIDTH = 16;
  localparam int IN_W      = 17;
  localparam int OUT_W     = 18;
  localparam int MAG_W     = 17;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_WIDTH_IN_USE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_APPROX_LOW_BITS = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 5'd16;
  localparam logic [CFG_W-1:0] APPROX_RESET = 5'd0;
  localparam logic [CFG_W-1:0] MAX_WIDTH_C  = CFG_W'(MAX_WIDTH);

  typedef logic [MAG_W-1:0] mag_t;

  // low n bits set
  function automatic mag_t mask_of(input logic [CFG_W:0] n);
    mag_t m;
    for (int i = 0; i < MAG_W; i++) begin
      m[i] = (CFG_W'(i) < n);
    end
    return m;
  endfunction

  // lower-part or add: bits under lowm are x|y, upper part adds with
  // carry-in x&y taken from the top or bit
  function automatic mag_t lpo_add(input mag_t x, input mag_t y, input mag_t wmask,
                                   input mag_t lowm, input mag_t keepm);
    mag_t xm;
    mag_t ym;
    mag_t kbit;
    mag_t cin;
    mag_t hi;
    xm   = x & wmask;
    ym   = y & wmask;
    kbit = lowm ^ (lowm >> 1);
    cin  = (|(xm & ym & kbit)) ? (lowm + mag_t'(1)) : '0;
    hi   = (xm & ~lowm) + (ym & ~lowm) + cin;
    return (((xm | ym) & lowm) | (hi & ~lowm)) & keepm;
  endfunction

endpackage

FILE: src/lower_or_sign_magnitude_adder.sv
// top level of the lower-part or sign-magnitude adder
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_stall   | operand_a, operand_b (17b signed)
//  out     | out_valid / out_stall | approx_sum (18b signed)
//  cfg     | cfg_valid / cfg_ready | cfg_index (2b), cfg_data (5b)
//
// one transaction per cycle sustained while out_stall is low; the input
// register feeds the adder path into the result register
// the single adder path (magnitude compare, two chained lpo adds, negate)
// sets the cycle time
// rst is synchronous: clears valids, config back to width 16, exact add
// a stalled result holds while one more input transaction can still land
// in the input register; in_stall rises only when both are full
module lower_or_sign_magnitude_adder
  import loa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  operand_a,
  input  logic signed [IN_W-1:0]  operand_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] approx_sum,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // config registers
  logic [CFG_W-1:0] width_in_use;
  logic [CFG_W-1:0] approx_low_bits;

  // input register stage
  logic                   s1_valid;
  logic signed [IN_W-1:0] s1_a;
  logic signed [IN_W-1:0] s1_b;

  // pipeline control
  logic out_adv;
  logic in_take;

  // clamped config and derived masks
  logic [CFG_W-1:0] wc;
  logic [CFG_W-1:0] kc;
  logic [CFG_W-1:0] wk;
  mag_t             trunc_mask;
  mag_t             wmask;
  mag_t             lowm;
  mag_t             keep_add;

  // datapath
  mag_t             ma;
  mag_t             mb;
  mag_t             big;
  mag_t             small_mag;
  mag_t             neg_small;
  mag_t             v;
  logic             negative;
  logic             subtract;
  logic [OUT_W-1:0] sum_next;

  assign cfg_ready = 1'b1;

  // config write port, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use    <= WIDTH_RESET;
      approx_low_bits <= APPROX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE:    width_in_use    <= cfg_data;
        REG_APPROX_LOW_BITS: approx_low_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register frees when empty or being taken
  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_a <= operand_a;
      s1_b <= operand_b;
    end
  end

  // width 0 acts as 1, both fields saturate at the max width
  always_comb begin
    if (width_in_use == '0) begin
      wc = CFG_W'(1);
    end else if (width_in_use > MAX_WIDTH_C) begin
      wc = MAX_WIDTH_C;
    end else begin
      wc = width_in_use;
    end
    kc         = (approx_low_bits > MAX_WIDTH_C) ? MAX_WIDTH_C : approx_low_bits;
    wk         = (wc > kc) ? wc : kc;
    trunc_mask = mask_of({1'b0, wc});
    wmask      = mask_of({1'b0, wk});
    lowm       = mask_of({1'b0, kc});
    // carry out appended only when some exact upper part exists
    keep_add   = (kc >= wk) ? wmask : mask_of({1'b0, wk} + (CFG_W+1)'(1));
  end

  always_comb begin
    // full magnitudes, 17 bits hold 65536
    ma = s1_a[IN_W-1] ? mag_t'(-s1_a) : mag_t'(s1_a);
    mb = s1_b[IN_W-1] ? mag_t'(-s1_b) : mag_t'(s1_b);

    // sign of the larger magnitude, positive on a tie
    if (ma > mb) begin
      negative = s1_a[IN_W-1];
    end else if (mb > ma) begin
      negative = s1_b[IN_W-1];
    end else begin
      negative = 1'b0;
    end
    subtract = (s1_a != '0) && (s1_b != '0) && (s1_a[IN_W-1] != s1_b[IN_W-1]);

    // pick by full value, then cut to the width in use
    big       = ((ma > mb) ? ma : mb) & trunc_mask;
    small_mag = ((ma > mb) ? mb : ma) & trunc_mask;

    // subtract: not-min plus one through the same adder, carry dropped
    neg_small = lpo_add(~small_mag, mag_t'(1), wmask, lowm, wmask);
    if (subtract) begin
      v = lpo_add(big, neg_small, wmask, lowm, wmask);
    end else begin
      v = lpo_add(big, small_mag, wmask, lowm, keep_add);
    end

    sum_next = negative ? (OUT_W'(0) - {1'b0, v}) : {1'b0, v};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      approx_sum <= sum_next;
    end
  end

`ifndef SYNTH
  // input side only blocks when the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without a held item");

  // an accepted transaction always lands in the input register
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost");

  // a held item moves into a free result register
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_adv) |=> out_valid)
    else $error("item dropped between stages");

  // result taken with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated");
`endif

endmodule

FILE: bench/lower_or_sign_magnitude_adder_tb.sv
// self-checking testbench for the lower-part or sign-magnitude adder
module lower_or_sign_magnitude_adder_tb
  import loa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam logic signed [IN_W-1:0] OPERAND_MIN = 17'sh10000;
  localparam logic signed [IN_W-1:0] OPERAND_MAX = 17'sh0ffff;

  // cycles in a row with no transaction on any channel before giving up
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_PHASES = 19;
  localparam int ITEMS_PER_PHASE = 100;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [IN_W-1:0]  operand_a;
  logic signed [IN_W-1:0]  operand_b;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] approx_sum;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  // shadow copy of the two config registers, as the block should hold them
  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_W-1:0] approx_reg = APPROX_RESET;

  // sums still owed by the block, oldest first
  logic signed [OUT_W-1:0] expected_sums[$];

  int  mismatches = 0;
  int  stuck_cycles = 0;
  bit  idle_on = 1'b1;

  lower_or_sign_magnitude_adder DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .approx_sum (approx_sum),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // low n bits set, n up to 17
  function automatic logic [OUT_W-1:0] ones(input int n);
    return (18'd1 << n) - 18'd1;
  endfunction

  // w-bit add where the low k bits are x|y and the upper part takes the
  // and of the top or bit as its carry in; keep_carry adds one bit on top
  function automatic logic [OUT_W-1:0] or_low_add(input logic [MAG_W-1:0] x,
                                                  input logic [MAG_W-1:0] y,
                                                  input int k, input int w,
                                                  input bit keep_carry);
    logic [OUT_W-1:0] xm;
    logic [OUT_W-1:0] ym;
    logic [OUT_W-1:0] lowbits;
    logic [OUT_W-1:0] hi;
    logic             carry;
    xm = {1'b0, x} & ones(w);
    ym = {1'b0, y} & ones(w);
    // every bit is or'd, and nothing is carried out
    if (k >= w) begin
      return xm | ym;
    end
    lowbits = (xm | ym) & ones(k);
    carry = 1'b0;
    if (k > 0) begin
      carry = xm[k-1] & ym[k-1];
    end
    hi = (xm >> k) + (ym >> k) + {17'd0, carry};
    hi = hi & (keep_carry ? ones(w - k + 1) : ones(w - k));
    return lowbits | (hi << k);
  endfunction

  // expected signed sum for one operand pair under the given config
  function automatic logic signed [OUT_W-1:0] lpo_sum(input logic signed [IN_W-1:0] a,
                                                      input logic signed [IN_W-1:0] b,
                                                      input logic [CFG_W-1:0] wsel,
                                                      input logic [CFG_W-1:0] ksel);
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] big;
    logic [MAG_W-1:0] little;
    logic [OUT_W-1:0] neg_little;
    logic [OUT_W-1:0] mag;
    int               width;
    int               k;
    int               w;
    bit               negative;
    bit               subtract;
    // magnitude of the most negative operand wraps to 2^16 in 17 bits
    ma = (a < 0) ? MAG_W'(-a) : MAG_W'(a);
    mb = (b < 0) ? MAG_W'(-b) : MAG_W'(b);
    // zero width reads as one, oversize values clamp to the maximum
    width = (wsel == 0) ? 1 : ((wsel > MAX_WIDTH) ? MAX_WIDTH : int'(wsel));
    k = (ksel > MAX_WIDTH) ? MAX_WIDTH : int'(ksel);
    w = (width > k) ? width : k;
    // sign follows the larger full magnitude, a tie is positive
    negative = 1'b0;
    if (ma > mb) begin
      negative = (a < 0);
    end else if (mb > ma) begin
      negative = (b < 0);
    end
    subtract = (a != 0) && (b != 0) && ((a < 0) != (b < 0));
    big = ((ma > mb) ? ma : mb) & MAG_W'(ones(width));
    little = ((ma > mb) ? mb : ma) & MAG_W'(ones(width));
    if (subtract) begin
      // two's complement of the smaller magnitude through the same adder
      neg_little = or_low_add(~little, MAG_W'(1), k, w, 1'b0);
      mag = or_low_add(big, neg_little[MAG_W-1:0], k, w, 1'b0);
    end else begin
      mag = or_low_add(big, little, k, w, 1'b1);
    end
    return negative ? -$signed(mag) : $signed(mag);
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // every result transaction is matched against the oldest owed sum
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result approx_sum=%0d", approx_sum));
      end else if (approx_sum !== expected_sums[0]) begin
        report_mismatch($sformatf("approx_sum=%0d, want %0d",
                                  approx_sum, expected_sums[0]));
        void'(expected_sums.pop_front());
      end else begin
        void'(expected_sums.pop_front());
      end
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("lower_or_sign_magnitude_adder regression: fail");
      $finish;
    end
  end

  // result side backpressure: a random hold-off before each result while idle_on is set
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      // stall is low from here on, so the next valid edge is a transaction
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // offers one operand pair, after a random gap while idle_on is set, and waits for its transaction;
  // valid stays high on return so back-to-back pairs run without a bubble
  task automatic send_pair(input logic signed [IN_W-1:0] a,
                           input logic signed [IN_W-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
    expected_sums.push_back(lpo_sum(a, b, width_reg, approx_reg));
  endtask

  // stop offering and wait until every owed sum has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // one config write; only ever called with the datapath idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH_IN_USE) begin
      width_reg = data;
    end else if (idx == REG_APPROX_LOW_BITS) begin
      approx_reg = data;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] wsel, input logic [CFG_W-1:0] ksel);
    wait_idle();
    write_reg(REG_WIDTH_IN_USE, wsel);
    write_reg(REG_APPROX_LOW_BITS, ksel);
  endtask

  // operand mix: mostly full range, some near zero, some at the ends
  function automatic logic signed [IN_W-1:0] rand_operand();
    int pick;
    int t;
    pick = $urandom_range(0, 7);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0: return OPERAND_MIN;
          1: return OPERAND_MAX;
          2: return -17'sd1;
          3: return 17'sd1;
          default: return 17'sd0;
        endcase
      end
      1, 2: begin
        t = $urandom_range(0, 40);
        return IN_W'(t - 20);
      end
      default: return IN_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset config (16 bits, exact): ends of the operand range and sign mixes
  task automatic test_operand_extremes();
    send_pair(OPERAND_MAX, OPERAND_MAX);
    send_pair(OPERAND_MIN, OPERAND_MIN);
    send_pair(OPERAND_MIN, OPERAND_MAX);
    send_pair(OPERAND_MAX, OPERAND_MIN);
    send_pair(17'sd0, 17'sd0);
    send_pair(17'sd0, OPERAND_MIN);
    send_pair(-17'sd1, 17'sd0);
    send_pair(17'sd1, -17'sd1);
    send_pair(-17'sd7, 17'sd7);
    send_pair(17'sd300, -17'sd45);
    send_pair(-17'sd300, 17'sd45);
    send_pair(-17'sd1234, -17'sd4321);
  endtask

  task automatic test_special_cases();
    // zero width behaves as one bit
    set_config(5'd0, 5'd0);
    send_pair(17'sd3, 17'sd2);
    send_pair(-17'sd3, -17'sd5);
    // oversize width clamps to the maximum
    set_config(5'd31, 5'd0);
    send_pair(17'sd40000, -17'sd1);
    // oversize or count clamps too, and then every bit is or'd
    set_config(5'd31, 5'd31);
    send_pair(17'sh05555, 17'sh02aaa);
    send_pair(-17'sh01234, 17'sh00f0f);
    // or count equal to the working width: pure or, no carry out
    set_config(5'd8, 5'd12);
    send_pair(17'sd200, 17'sd100);
    // truncated larger magnitude falls below the smaller, result wraps
    set_config(5'd4, 5'd0);
    send_pair(17'sd17, -17'sd5);
    send_pair(-17'sd33, 17'sd14);
    // equal magnitudes under an approximate subtract may leave a residue
    set_config(5'd16, 5'd4);
    send_pair(17'sd3, -17'sd3);
    send_pair(-17'sd13, 17'sd13);
    send_pair(17'sd12345, -17'sd12345);
    // a write to an unmapped index must leave the config alone
    wait_idle();
    write_reg(REG_UNMAPPED, 5'd0);
    send_pair(17'sd1000, -17'sd999);
  endtask

  // random pairs over many config settings, extremes first
  task automatic test_random_pairs();
    logic [CFG_W-1:0]        wtab[6] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd16, 5'd2};
    logic [CFG_W-1:0]        ktab[6] = '{5'd0, 5'd16, 5'd31, 5'd0, 5'd15, 5'd1};
    logic signed [IN_W-1:0]  a;
    logic signed [IN_W-1:0]  b;
    int                      pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 6) begin
        set_config(wtab[phase], ktab[phase]);
      end else begin
        set_config(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNMAPPED, CFG_W'($urandom()));
      end
      // every third phase runs flat out on both sides
      idle_on = (phase % 3) != 2;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        a = rand_operand();
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          b = -a;
        end else if (pick == 1) begin
          b = a;
        end else begin
          b = rand_operand();
        end
        send_pair(a, b);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    operand_a <= '0;
    operand_b <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH_IN_USE;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operand_extremes();
    test_special_cases();
    test_random_pairs();

    wait_idle();
    // two-stage pipe, give a stray extra result time to show up
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("lower_or_sign_magnitude_adder regression: pass");
    end else begin
      $display("lower_or_sign_magnitude_adder regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/loa_pkg.sv
src/lower_or_sign_magnitude_adder.sv
bench/lower_or_sign_magnitude_adder_tb.sv
